// ----- rtl/core/trapezoidal_time_scaling_macros.svh -----
// Assertion macros for the trapezoidal time scaling block.
`ifndef TRAPEZOIDAL_TIME_SCALING_MACROS_SVH
`define TRAPEZOIDAL_TIME_SCALING_MACROS_SVH
`ifndef ASSERT_OFF
`define TTS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define TTS_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TTS_ASSERT(label, clk, rst, prop)
`define TTS_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- rtl/core/tts_pkg.sv -----
package tts_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W = 32;
   localparam int PROD_W = 3 * DATA_W;
   localparam int NUM_W = 3 * DATA_W + 1;
   localparam int DEN_W = 2 * DATA_W + 1;

   typedef enum logic [1:0] {
      SEG_ACCEL  = 2'd0,
      SEG_CRUISE = 2'd1,
      SEG_DECEL  = 2'd2
   } tts_seg_type;

   typedef enum logic [1:0] {
      CSR_TOTAL_TIME    = 2'd0,
      CSR_PEAK_VELOCITY = 2'd1,
      CSR_PEAK_ACCEL    = 2'd2,
      CSR_PATH_LENGTH   = 2'd3
   } tts_csr_type;

   typedef struct packed {
      logic [DATA_W-1:0] total_time;
      logic [DATA_W-1:0] peak_velocity;
      logic [DATA_W-1:0] peak_acceleration;
      logic [DATA_W-1:0] path_length;
   } tts_cfg_type;

   typedef struct packed {
      tts_seg_type seg;
      logic        force_one;
      logic        decel;
   } tts_tag_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      tts_tag_type      tag;
   } tts_frac_type;

endpackage

// ----- rtl/core/tts_front.sv -----
`include "trapezoidal_time_scaling_macros.svh"

module tts_front #(
   parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tts_pkg::tts_cfg_type       cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [tts_pkg::DATA_W-1:0] in_time,
   output logic                       out_valid,
   input  logic                       out_ready,
   output tts_pkg::tts_frac_type      out_frac
);

   localparam int DW = tts_pkg::DATA_W;
   localparam int PW = 2 * DW;
   localparam int NW = tts_pkg::NUM_W;
   localparam int EW = tts_pkg::DEN_W;
   localparam int NS = 5;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] vin;
   logic [NS-1:0] rdy;

   assign vin = {v_ff[NS-2:0], in_valid};
   assign rdy[NS-1] = !v_ff[NS-1] || out_ready;
   for (genvar i = 0; i < NS - 1; i++) begin : g_rdy
      assign rdy[i] = !v_ff[i] || rdy[i+1];
   end
   assign in_ready = rdy[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= vin[i];
            end
         end
      end
   end

   // stage 1: products of time and config
   logic [DW-1:0] s1_t_ff, s1_dt_ff;
   logic [PW-1:0] s1_tsq_ff, s1_ta_ff, s1_bigta_ff, s1_av_ff, s1_vv_ff, s1_as_ff;
   logic          s1_gt_ff;
   logic [PW-1:0] s1_tsq_in, s1_ta_in, s1_bigta_in, s1_av_in, s1_vv_in, s1_as_in;

   always_comb begin
      s1_tsq_in   = in_time * in_time;
      s1_ta_in    = in_time * cfg.peak_acceleration;
      s1_bigta_in = cfg.total_time * cfg.peak_acceleration;
      s1_av_in    = cfg.peak_acceleration * cfg.peak_velocity;
      s1_vv_in    = cfg.peak_velocity * cfg.peak_velocity;
      s1_as_in    = cfg.peak_acceleration * cfg.path_length;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_t_ff     <= in_time;
         s1_dt_ff    <= cfg.total_time - in_time;
         s1_gt_ff    <= in_time > cfg.total_time;
         s1_tsq_ff   <= s1_tsq_in;
         s1_ta_ff    <= s1_ta_in;
         s1_bigta_ff <= s1_bigta_in;
         s1_av_ff    <= s1_av_in;
         s1_vv_ff    <= s1_vv_in;
         s1_as_ff    <= s1_as_in;
      end
   end

   // stage 2: pick segment, square remaining time
   logic [DW-1:0]        s2_t_ff;
   logic [PW-1:0]        s2_tsq_ff, s2_dtsq_ff, s2_av_ff, s2_vv_ff, s2_as_ff;
   logic                 s2_gt_ff;
   tts_pkg::tts_seg_type s2_seg_ff, s2_seg_in;
   logic [PW-1:0]        s2_dtsq_in, vsh;
   logic                 tri_prof, accel, cruise;

   always_comb begin
      vsh      = PW'(cfg.peak_velocity) << FRAC_BITS;
      tri_prof = s1_as_ff < s1_vv_ff;
      accel    = tri_prof ? ({s1_t_ff, 1'b0} <= {1'b0, cfg.total_time})
                          : (s1_ta_ff <= vsh);
      cruise   = !tri_prof && ((s1_bigta_ff - s1_ta_ff) >= vsh);
      if (s1_gt_ff) begin
         s2_seg_in = tts_pkg::SEG_DECEL;
      end else if (accel) begin
         s2_seg_in = tts_pkg::SEG_ACCEL;
      end else if (cruise) begin
         s2_seg_in = tts_pkg::SEG_CRUISE;
      end else begin
         s2_seg_in = tts_pkg::SEG_DECEL;
      end
      s2_dtsq_in = s1_dt_ff * s1_dt_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s2_t_ff    <= s1_t_ff;
         s2_tsq_ff  <= s1_tsq_ff;
         s2_dtsq_ff <= s2_dtsq_in;
         s2_av_ff   <= s1_av_ff;
         s2_vv_ff   <= s1_vv_ff;
         s2_as_ff   <= s1_as_ff;
         s2_gt_ff   <= s1_gt_ff;
         s2_seg_ff  <= s2_seg_in;
      end
   end

   // stage 3: partial products of the numerator
   logic [PW-1:0]        s3_pl_ff, s3_ph_ff, s3_vv_ff, s3_as_ff;
   logic                 s3_gt_ff;
   tts_pkg::tts_seg_type s3_seg_ff;
   logic [PW-1:0]        s3_pl_in, s3_ph_in, mx;
   logic [DW-1:0]        my;

   always_comb begin
      case (s2_seg_ff)
         tts_pkg::SEG_CRUISE: begin
            mx = s2_av_ff;
            my = s2_t_ff;
         end
         tts_pkg::SEG_ACCEL: begin
            mx = s2_tsq_ff;
            my = cfg.peak_acceleration;
         end
         default: begin
            mx = s2_dtsq_ff;
            my = cfg.peak_acceleration;
         end
      endcase
      s3_pl_in = mx[DW-1:0] * my;
      s3_ph_in = mx[PW-1:DW] * my;
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s3_pl_ff  <= s3_pl_in;
         s3_ph_ff  <= s3_ph_in;
         s3_vv_ff  <= s2_vv_ff;
         s3_as_ff  <= s2_as_ff;
         s3_gt_ff  <= s2_gt_ff;
         s3_seg_ff <= s2_seg_ff;
      end
   end

   // stage 4: sum partial products
   logic [tts_pkg::PROD_W-1:0] s4_prod_ff, s4_prod_in;
   logic [PW-1:0]              s4_vv_ff, s4_as_ff;
   logic                       s4_gt_ff;
   tts_pkg::tts_seg_type       s4_seg_ff;

   assign s4_prod_in = {{DW{1'b0}}, s3_pl_ff} + {s3_ph_ff, {DW{1'b0}}};

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s4_prod_ff <= s4_prod_in;
         s4_vv_ff   <= s3_vv_ff;
         s4_as_ff   <= s3_as_ff;
         s4_gt_ff   <= s3_gt_ff;
         s4_seg_ff  <= s3_seg_ff;
      end
   end

   // stage 5: numerator and denominator
   tts_pkg::tts_frac_type s5_frac_ff, s5_frac_in;
   logic [NW-1:0]         s5_vvsh, s5_prod2;

   always_comb begin
      s5_vvsh  = NW'(s4_vv_ff) << FRAC_BITS;
      s5_prod2 = {s4_prod_ff, 1'b0};
      if (s4_seg_ff == tts_pkg::SEG_CRUISE) begin
         s5_frac_in.num = s5_prod2 - s5_vvsh;
         s5_frac_in.den = {s4_as_ff, 1'b0};
      end else begin
         s5_frac_in.num = {1'b0, s4_prod_ff};
         s5_frac_in.den = EW'(cfg.path_length) << (FRAC_BITS + 1);
      end
      s5_frac_in.tag.seg       = s4_seg_ff;
      s5_frac_in.tag.force_one = s4_gt_ff || (cfg.path_length == '0);
      s5_frac_in.tag.decel     = (s4_seg_ff == tts_pkg::SEG_DECEL) && !s4_gt_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s5_frac_ff <= s5_frac_in;
      end
   end

   assign out_frac = s5_frac_ff;

   `TTS_ASSERT(a_cruise_num_pos, clock, reset, v_ff[3] && s4_seg_ff == tts_pkg::SEG_CRUISE |-> s5_prod2 >= s5_vvsh)

endmodule

// ----- rtl/core/tts_div.sv -----
`include "trapezoidal_time_scaling_macros.svh"

module tts_div #(
   parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tts_pkg::tts_frac_type in_frac,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [FRAC_BITS:0]    out_quot,
   output logic                  out_inexact,
   output logic                  out_sat,
   output tts_pkg::tts_tag_type  out_tag
);

   localparam int NW = tts_pkg::NUM_W;
   localparam int EW = tts_pkg::DEN_W;
   localparam int QW = FRAC_BITS + 1;
   localparam int NS = QW + 1;
   localparam int RW = EW + 1;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] vin;
   logic [NS-1:0] rdy;

   assign vin = {v_ff[NS-2:0], in_valid};
   assign rdy[NS-1] = !v_ff[NS-1] || out_ready;
   for (genvar i = 0; i < NS - 1; i++) begin : g_rdy
      assign rdy[i] = !v_ff[i] || rdy[i+1];
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= vin[i];
            end
         end
      end
   end

   logic [RW-1:0]        rem_ff [NS];
   logic [QW-1:0]        nlo_ff [NS];
   logic [QW-1:0]        q_ff   [NS];
   logic [EW-1:0]        den_ff [NS];
   logic [NS-1:0]        sat_ff;
   tts_pkg::tts_tag_type tag_ff [NS];

   logic [RW-1:0]        rem_in [NS];
   logic [QW-1:0]        nlo_in [NS];
   logic [QW-1:0]        q_in   [NS];
   logic [EW-1:0]        den_in [NS];
   logic [NS-1:0]        sat_in;
   tts_pkg::tts_tag_type tag_in [NS];
   logic [RW-1:0]        trial  [NS];
   logic [NS-1:0]        ge;

   always_comb begin
      trial[0]  = '0;
      ge[0]     = 1'b0;
      rem_in[0] = RW'(in_frac.num[NW-1:QW]);
      nlo_in[0] = in_frac.num[QW-1:0];
      q_in[0]   = '0;
      den_in[0] = in_frac.den;
      sat_in[0] = in_frac.num >= (NW'(in_frac.den) << QW);
      tag_in[0] = in_frac.tag;
      for (int k = 1; k < NS; k++) begin
         trial[k]  = {rem_ff[k-1][RW-2:0], nlo_ff[k-1][QW-1]};
         ge[k]     = trial[k] >= RW'(den_ff[k-1]);
         rem_in[k] = ge[k] ? trial[k] - RW'(den_ff[k-1]) : trial[k];
         nlo_in[k] = nlo_ff[k-1] << 1;
         q_in[k]   = {q_ff[k-1][QW-2:0], ge[k]};
         den_in[k] = den_ff[k-1];
         sat_in[k] = sat_ff[k-1];
         tag_in[k] = tag_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (rdy[k]) begin
            rem_ff[k] <= rem_in[k];
            nlo_ff[k] <= nlo_in[k];
            q_ff[k]   <= q_in[k];
            den_ff[k] <= den_in[k];
            sat_ff[k] <= sat_in[k];
            tag_ff[k] <= tag_in[k];
         end
      end
   end

   assign out_valid   = v_ff[NS-1];
   assign out_quot    = q_ff[NS-1];
   assign out_inexact = rem_ff[NS-1] != '0;
   assign out_sat     = sat_ff[NS-1];
   assign out_tag     = tag_ff[NS-1];

   `TTS_ASSERT(a_rem_below_den, clock, reset, v_ff[NS-1] && !sat_ff[NS-1] |-> rem_ff[NS-1] < RW'(den_ff[NS-1]))

endmodule

// ----- rtl/core/trapezoidal_time_scaling.sv -----
// Trapezoidal velocity profile time scaling.
// req_ channel: one 32-bit time stamp word (Q16.16 seconds) per accepted word.
// rsp_ channel: one word per request, in order: normalized progress (Q1.16,
//   saturated to 0..1.0) and the segment (accelerate, cruise, decelerate).
// csr_ channel: writes total time, peak velocity, peak acceleration and path
//   length by index 0 to 3; csr_ready is always high. Write only while idle.
// Throughput: one word per cycle while the rsp_ side does not stall. The
//   pipeline is five product stages, a restoring divider that retires one
//   quotient bit per stage, and the output register.
// Reset clears all pipeline valid bits and loads every CSR with 1.0.
// A stalled rsp_ side holds the output word; upstream stages keep accepting
//   words until their own bubbles are filled, then req_tready drops. Nothing
//   is lost or repeated across stalls.
`include "trapezoidal_time_scaling_macros.svh"

module trapezoidal_time_scaling #(
   parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF,
   localparam int RSP_W = ((FRAC_BITS + 3 + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [tts_pkg::DATA_W-1:0] req_tdata,   // time_stamp
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_W-1:0]           rsp_tdata,   // progress, segment
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [tts_pkg::DATA_W-1:0] csr_data
);

   localparam int DW = tts_pkg::DATA_W;
   localparam int QW = FRAC_BITS + 1;
   localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

   tts_pkg::tts_cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_time        <= DW'(1) << FRAC_BITS;
         cfg_ff.peak_velocity     <= DW'(1) << FRAC_BITS;
         cfg_ff.peak_acceleration <= DW'(1) << FRAC_BITS;
         cfg_ff.path_length       <= DW'(1) << FRAC_BITS;
      end else if (csr_valid) begin
         case (tts_pkg::tts_csr_type'(csr_index))
            tts_pkg::CSR_TOTAL_TIME:    cfg_ff.total_time        <= csr_data;
            tts_pkg::CSR_PEAK_VELOCITY: cfg_ff.peak_velocity     <= csr_data;
            tts_pkg::CSR_PEAK_ACCEL:    cfg_ff.peak_acceleration <= csr_data;
            tts_pkg::CSR_PATH_LENGTH:   cfg_ff.path_length       <= csr_data;
            default: ;
         endcase
      end
   end

   logic                  fr_valid, fr_ready;
   tts_pkg::tts_frac_type fr_frac;
   logic                  dv_valid, dv_ready;
   logic [QW-1:0]         dv_quot;
   logic                  dv_inexact, dv_sat;
   tts_pkg::tts_tag_type  dv_tag;

   tts_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_time   (req_tdata),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_frac  (fr_frac)
   );

   tts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (fr_valid),
      .in_ready    (fr_ready),
      .in_frac     (fr_frac),
      .out_valid   (dv_valid),
      .out_ready   (dv_ready),
      .out_quot    (dv_quot),
      .out_inexact (dv_inexact),
      .out_sat     (dv_sat),
      .out_tag     (dv_tag)
   );

   logic                 rsp_valid_ff;
   logic [QW-1:0]        progress_ff, progress_in;
   tts_pkg::tts_seg_type segment_ff;
   logic [QW:0]          xsum;

   assign dv_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      xsum = {1'b0, dv_quot} + (QW+1)'(dv_inexact);
      if (dv_tag.force_one) begin
         progress_in = ONE;
      end else if (dv_tag.decel) begin
         progress_in = (dv_sat || xsum >= {1'b0, ONE}) ? '0 : QW'({1'b0, ONE} - xsum);
      end else begin
         progress_in = (dv_sat || dv_quot >= ONE) ? ONE : dv_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dv_ready) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ready) begin
         progress_ff <= progress_in;
         segment_ff  <= dv_tag.seg;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({segment_ff, progress_ff});

   `TTS_ASSERT(a_progress_range, clock, reset, rsp_tvalid |-> progress_ff <= ONE)
   `TTS_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

// ----- tb/tb_trapezoidal_time_scaling.sv -----
`timescale 1ns / 1ps

module tb_trapezoidal_time_scaling;

   localparam int FB = tts_pkg::FRAC_BITS_DEF;
   localparam int RSP_W = ((FB + 3 + 7) / 8) * 8;
   localparam logic [63:0] ONE = 64'd1 << FB;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [16:0]          progress;
      tts_pkg::tts_seg_type seg;
   } progress_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   logic [31:0] move_time, max_vel, max_acc, path_len;
   progress_word_type progress_q[$];
   int mismatches = 0;
   int hold_off = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int random_gaps = 1;

   trapezoidal_time_scaling DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // floor(n / d) clamped to lim; inexact reports a remainder
   function automatic logic [63:0] div_clamp(logic [191:0] n, logic [191:0] d,
                                            logic [63:0] lim, output logic inexact);
      logic [191:0] q;
      begin
         inexact = 1'b0;
         if (d == 0) return lim;
         q = n / d;
         inexact = (n % d) != 0;
         if (q > lim) return lim;
         return q[63:0];
      end
   endfunction

   function automatic progress_word_type scale_time(logic [31:0] ts);
      logic [191:0] t, tt, vv, aa, ss, vshift, den, num, x;
      logic tri_prof, inex;
      logic [63:0] p;
      progress_word_type r;
      begin
         t = ts; tt = move_time; vv = max_vel; aa = max_acc; ss = path_len;
         vshift = vv << FB;
         den = ss << (FB + 1);
         tri_prof = (aa * ss) < (vv * vv);
         if (t > tt) begin
            r.seg = tts_pkg::SEG_DECEL; p = ONE;
         end else if (tri_prof ? (2 * t <= tt) : (t * aa <= vshift)) begin
            r.seg = tts_pkg::SEG_ACCEL;
            p = div_clamp(aa * t * t, den, ONE, inex);
         end else if (!tri_prof && (tt * aa - t * aa >= vshift)) begin
            r.seg = tts_pkg::SEG_CRUISE;
            num = ((aa * vv * t) << 1) - ((vv * vv) << FB);
            p = div_clamp(num, (aa * ss) << 1, ONE, inex);
         end else begin
            r.seg = tts_pkg::SEG_DECEL;
            x = div_clamp(aa * (tt - t) * (tt - t), den, ONE + 1, inex);
            if (inex) x = x + 1;
            p = (x >= ONE) ? 64'd0 : ONE - x[63:0];
         end
         if (path_len == 0) p = ONE;
         r.progress = p[16:0];
         return r;
      end
   endfunction

   task automatic idle_cycles(int n);
      repeat (n) @(negedge clock);
   endtask

   task automatic send_time(logic [31:0] ts);
      int gap;
      gap = random_gaps ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         idle_cycles(gap);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ts;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      progress_q = {progress_q, scale_time(ts)};
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (progress_q.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      idle_cycles(40);
   endtask

   task automatic write_reg(tts_pkg::tts_csr_type idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         tts_pkg::CSR_TOTAL_TIME: move_time = val;
         tts_pkg::CSR_PEAK_VELOCITY: max_vel = val;
         tts_pkg::CSR_PEAK_ACCEL: max_acc = val;
         default: path_len = val;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_profile(logic [31:0] t, logic [31:0] v, logic [31:0] a,
                              logic [31:0] s);
      drain();
      write_reg(tts_pkg::CSR_TOTAL_TIME, t);
      write_reg(tts_pkg::CSR_PEAK_VELOCITY, v);
      write_reg(tts_pkg::CSR_PEAK_ACCEL, a);
      write_reg(tts_pkg::CSR_PATH_LENGTH, s);
   endtask

   // time stamps biased into 0..T with some past the end
   task automatic random_times(int n);
      logic [31:0] ts;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: ts = $urandom;
            1: ts = move_time + $urandom_range(0, 3);
            2: ts = move_time - $urandom_range(0, 3);
            default: ts = (move_time == 0) ? 32'd0 :
                          32'(({32'd0, $urandom} * move_time) >> 32);
         endcase
         send_time(ts);
      end
   endtask

   task automatic test_reset_profile();
      send_time(32'd0);
      send_time(32'h0000_8000);
      send_time(32'h0000_FFFF);
      send_time(32'h0001_0000);
      send_time(32'h0001_0001);
      send_time(32'hFFFF_FFFF);
      send_time(32'h0000_4000);
      send_time(32'h0000_C000);
   endtask

   task automatic test_special_profiles();
      set_profile(32'h0004_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      for (int i = 0; i <= 8; i++) send_time(32'h0000_8000 * i);
      set_profile(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'd0);
      send_time(32'h0000_8000);
      send_time(32'h0001_8000);
      set_profile(32'h0002_0000, 32'h0001_0000, 32'd0, 32'h0001_0000);
      send_time(32'h0000_8000);
      send_time(32'h0001_8000);
      set_profile(32'd0, 32'd0, 32'd0, 32'd0);
      send_time(32'd0);
      send_time(32'd1);
      set_profile(32'h0001_0000, 32'h0004_0000, 32'h0010_0000, 32'h0008_0000);
      send_time(32'h0000_8000);
      send_time(32'h0000_F000);
   endtask

   task automatic test_random_profiles();
      for (int p = 0; p < 24; p++) begin
         case (p % 4)
            0: set_profile($urandom, $urandom, $urandom, $urandom);
            1: set_profile($urandom_range(1, 32'h0010_0000),
                           $urandom_range(1, 32'h0004_0000),
                           $urandom_range(1, 32'h0004_0000),
                           $urandom_range(1, 32'h0004_0000));
            2: set_profile(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            default: set_profile(32'd1, 32'd1, 32'd1, 32'd1);
         endcase
         random_times(55);
      end
   endtask

   task automatic test_backpressure();
      set_profile(32'h0008_0000, 32'h0002_0000, 32'h0001_0000, 32'h000A_0000);
      random_gaps = 0;
      hold_req++;
      random_times(60);
      random_gaps = 1;
      drain();
      random_times(40);
   endtask

   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_off <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off <= hold_off - 1;
      end else if (random_gaps && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      progress_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.progress = rsp_tdata[16:0];
         got.seg = tts_pkg::tts_seg_type'(rsp_tdata[18:17]);
         if (progress_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_tdata);
         end else begin
            want = progress_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: progress exp %h got %h, segment exp %0d got %0d",
                           want.progress, got.progress, want.seg, got.seg);
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("trapezoidal_time_scaling regression: fail");
      $finish;
   end

   initial begin
      move_time = 32'h0001_0000;
      max_vel = 32'h0001_0000;
      max_acc = 32'h0001_0000;
      path_len = 32'h0001_0000;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_profile();
      test_special_profiles();
      test_backpressure();
      test_random_profiles();
      drain();
      if (mismatches == 0 && progress_q.size() == 0)
         $display("trapezoidal_time_scaling regression: pass");
      else
         $display("trapezoidal_time_scaling regression: fail");
      $finish;
   end
endmodule
